@@ rtl/core/sic_pkg.sv @@
// Shared constants for the string isomorphism check unit.
package sic_pkg;

  // Width of a symbol as it arrives on the input channel.
  localparam int unsigned SYM_FIELD_BITS = 8;

  // Width of the epoch tag kept in every map entry; tag zero means "never written".
  localparam int unsigned EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

endpackage

@@ rtl/core/sic_pair_if.sv @@
// Channel interface that carries one character pair word per handshake.
interface sic_pair_if;
  import sic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SYM_FIELD_BITS-1:0] first_symbol;
  logic [SYM_FIELD_BITS-1:0] second_symbol;
  logic                      has_pair;
  logic                      last;

  modport source (
    output valid, first_symbol, second_symbol, has_pair, last,
    input  ready
  );

  modport sink (
    input  valid, first_symbol, second_symbol, has_pair, last,
    output ready
  );
endinterface

@@ rtl/core/sic_verdict_if.sv @@
// Channel interface that carries one verdict word per handshake.
interface sic_verdict_if;
  logic valid;
  logic ready;
  logic is_isomorphic;

  modport source (
    output valid, is_isomorphic,
    input  ready
  );

  modport sink (
    input  valid, is_isomorphic,
    output ready
  );
endinterface

@@ rtl/core/sic_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sic_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/string_isomorphism_check_unit.sv @@
// Top level of the string isomorphism check unit: two map RAMs and the check pipeline.
//
//   channel    modport   word                                            role
//   pairs      sink      first_symbol, second_symbol, has_pair, last     one position
//   verdicts   source    is_isomorphic                                   one per string pair
//
// One pair word is taken every cycle unless the input is held; the verdict is registered
// as the last word leaves the check stage. Each word reads both map RAMs when taken and
// checks and writes back in the check stage; a one-entry bypass covers a write that
// lands while the next word is read. Map entries carry an epoch tag, so rearming costs
// nothing; after reset and every 255th string pair a clearing pass writes 2**SYMBOL_BITS
// entries, one a cycle, while no word is taken (plus a bubble if it follows a pair).
// A verdict waiting on the output stalls the pipeline only when the next verdict is due.
module string_isomorphism_check_unit #(
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic   clk,
  input  logic   rst,
  sic_pair_if    .sink   pairs,
  sic_verdict_if .source verdicts
);
  import sic_pkg::*;

  localparam int unsigned DEPTH      = 1 << SYMBOL_BITS;
  localparam int unsigned ENTRY_BITS = EPOCH_BITS + SYMBOL_BITS;

  typedef logic [SYMBOL_BITS-1:0] sym_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    sym_t                  partner;
  } entry_t;

  // Control state.
  logic                  sweep_active;
  sym_t                  sweep_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic                  verdict_ok;
  logic                  at_first;

  // Check stage.
  logic s1_valid;
  sym_t s1_a;
  sym_t s1_b;
  logic s1_pair;
  logic s1_last;

  // Bypass of the most recent map write.
  logic                  byp_valid;
  sym_t                  byp_a;
  sym_t                  byp_b;
  logic [EPOCH_BITS-1:0] byp_epoch;

  // Output register.
  logic out_valid;
  logic out_data;

  logic   accept;
  logic   s1_advance;
  logic   wrap_hold;
  sym_t   in_a;
  sym_t   in_b;
  entry_t fwd_rd;
  entry_t rev_rd;
  entry_t fwd_entry;
  entry_t rev_entry;
  logic   fwd_hit;
  logic   rev_hit;
  logic   clash;
  logic   verdict_now;
  logic   do_write;
  logic   fwd_wr_en;
  logic   rev_wr_en;
  sym_t   fwd_wr_addr;
  sym_t   rev_wr_addr;
  entry_t fwd_wr_data;
  entry_t rev_wr_data;
  logic [ENTRY_BITS-1:0] fwd_rd_bits;
  logic [ENTRY_BITS-1:0] rev_rd_bits;

  // Symbol bits beyond the configured width are dropped.
  assign in_a = SYMBOL_BITS'(pairs.first_symbol);
  assign in_b = SYMBOL_BITS'(pairs.second_symbol);

  // Handshake: a pending verdict stalls only a stage holding another last word.
  assign s1_advance   = !(s1_last && out_valid && !verdicts.ready);
  assign wrap_hold    = s1_valid && s1_last && (epoch == EPOCH_LAST);
  assign pairs.ready  = !sweep_active && !wrap_hold && (!s1_valid || s1_advance);
  assign accept       = pairs.valid && pairs.ready;

  assign verdicts.valid         = out_valid;
  assign verdicts.is_isomorphic = out_data;

  // Map RAMs: forward keyed by the first symbol, reverse by the second.
  sic_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_fwd_ram (
    .clk     (clk),
    .wr_en   (fwd_wr_en),
    .wr_addr (fwd_wr_addr),
    .wr_data (fwd_wr_data),
    .rd_en   (accept),
    .rd_addr (in_a),
    .rd_data (fwd_rd_bits)
  );

  sic_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_rev_ram (
    .clk     (clk),
    .wr_en   (rev_wr_en),
    .wr_addr (rev_wr_addr),
    .wr_data (rev_wr_data),
    .rd_en   (accept),
    .rd_addr (in_b),
    .rd_data (rev_rd_bits)
  );

  assign fwd_rd = entry_t'(fwd_rd_bits);
  assign rev_rd = entry_t'(rev_rd_bits);

  // Apply the bypass, then check both maps for a different partner.
  always_comb begin
    fwd_entry = fwd_rd;
    rev_entry = rev_rd;
    if (byp_valid && (byp_a == s1_a)) begin
      fwd_entry = '{epoch: byp_epoch, partner: byp_b};
    end
    if (byp_valid && (byp_b == s1_b)) begin
      rev_entry = '{epoch: byp_epoch, partner: byp_a};
    end
    fwd_hit     = (fwd_entry.epoch == epoch);
    rev_hit     = (rev_entry.epoch == epoch);
    clash       = s1_pair && ((rev_hit && (rev_entry.partner != s1_a)) ||
                              (fwd_hit && (fwd_entry.partner != s1_b)));
    verdict_now = verdict_ok && !clash && !(!s1_pair && at_first);
    do_write    = s1_valid && s1_advance && s1_pair && !clash;
  end

  // Write ports: the clearing pass takes them, otherwise the check stage.
  always_comb begin
    if (sweep_active) begin
      fwd_wr_en   = 1'b1;
      rev_wr_en   = 1'b1;
      fwd_wr_addr = sweep_addr;
      rev_wr_addr = sweep_addr;
      fwd_wr_data = '{epoch: EPOCH_NONE, partner: '0};
      rev_wr_data = '{epoch: EPOCH_NONE, partner: '0};
    end else begin
      fwd_wr_en   = do_write;
      rev_wr_en   = do_write;
      fwd_wr_addr = s1_a;
      rev_wr_addr = s1_b;
      fwd_wr_data = '{epoch: epoch, partner: s1_b};
      rev_wr_data = '{epoch: epoch, partner: s1_a};
    end
  end

  // Control state, clearing pass and epoch.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      epoch        <= EPOCH_FIRST;
      verdict_ok   <= 1'b1;
      at_first     <= 1'b1;
      s1_valid     <= 1'b0;
      byp_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (sweep_active) begin
        sweep_addr <= sweep_addr + 1'b1;
        byp_valid  <= 1'b0;
        if (sweep_addr == '1) begin
          sweep_active <= 1'b0;
          epoch        <= EPOCH_FIRST;
        end
      end

      // Stage register moves whenever the check stage frees up.
      if (!s1_valid || s1_advance) begin
        s1_valid <= accept;
      end

      if (do_write) begin
        byp_valid <= 1'b1;
      end

      // Running verdict, and rearm on the last word.
      if (s1_valid && s1_advance) begin
        if (s1_last) begin
          verdict_ok <= 1'b1;
          at_first   <= 1'b1;
          if (epoch == EPOCH_LAST) begin
            sweep_active <= 1'b1;
            sweep_addr   <= '0;
          end else begin
            epoch <= epoch + 1'b1;
          end
        end else begin
          verdict_ok <= verdict_now;
          at_first   <= 1'b0;
        end
      end

      // Output register.
      if (s1_valid && s1_advance && s1_last) begin
        out_valid <= 1'b1;
      end else if (verdicts.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a    <= in_a;
      s1_b    <= in_b;
      s1_pair <= pairs.has_pair;
      s1_last <= pairs.last;
    end
    if (do_write) begin
      byp_a     <= s1_a;
      byp_b     <= s1_b;
      byp_epoch <= epoch;
    end
    if (s1_valid && s1_advance && s1_last) begin
      out_data <= verdict_now;
    end
  end

  // A verdict only appears after a last word left the check stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("verdict raised without a last word");

  // The clearing pass never runs beside a word in the check stage.
  assert property (@(posedge clk) disable iff (rst)
    sweep_active |-> !s1_valid && !do_write)
    else $error("clearing pass overlaps a word in flight");

  // The live epoch never takes the tag reserved for unwritten entries.
  assert property (@(posedge clk) disable iff (rst)
    epoch != EPOCH_NONE)
    else $error("epoch reached the unwritten tag");

endmodule
